>>> design/rwct_pkg.sv
// shared types and constants for the raycast wall column texturer
package rwct_pkg;

  localparam int RAY_FRAC   = 14;
  localparam int ACC_W      = 40;
  localparam int STEP_W     = 32;
  localparam int DIV_D      = 24;
  localparam int ROW_W      = 11;
  localparam int COL_W      = 12;
  localparam int DIST_W     = 24;

  localparam logic CMD_SETUP = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    KIND_CEILING = 2'd0,
    KIND_FLOOR   = 2'd1,
    KIND_TEXEL   = 2'd2,
    KIND_DEPTH   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SCREEN_HEIGHT   = 3'd0,
    REG_TEX_WIDTH_LOG2  = 3'd1,
    REG_TEX_HEIGHT_LOG2 = 3'd2,
    REG_CEILING_COLOR   = 3'd3,
    REG_FLOOR_COLOR     = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_H,
    ST_SLICE,
    ST_DIV_S,
    ST_MUL,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [ROW_W-1:0] screen_height;
    logic [3:0]       tex_width_log2;
    logic [3:0]       tex_height_log2;
    logic [31:0]      ceiling_color;
    logic [31:0]      floor_color;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [COL_W-1:0]   column;
    logic [DIST_W-1:0]  wall_distance;
    logic               hit_side;
    logic signed [15:0] ray_dir_x;
    logic signed [15:0] ray_dir_y;
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  out_row;
    kind_t             pixel_kind;
    logic [1:0]        texture_select;
    logic [15:0]       texel_index;
    logic [31:0]       pixel_color;
    logic [DIST_W-1:0] depth;
  } res_t;

endpackage

>>> design/rwct_fifo.sv
// small register queue used between front, back and result side
module rwct_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd,
  output item_t rd_data,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> design/rwct_div.sv
// restoring divider, one quotient bit per cycle
module rwct_div #(
  parameter int N = 27,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  dq;
  logic [D-1:0]  rem;
  logic [D-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [D:0]    shifted;
  logic          fits;

  assign shifted  = {rem, dq[N-1]};
  assign fits     = (shifted >= {1'b0, dvs});
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[N-2:0], fits};
      rem <= fits ? D'(shifted - {1'b0, dvs}) : shifted[D-1:0];
    end
  end

endmodule

>>> design/rwct_back.sv
// back end: column setup sequencer and per-row pixel generation
module rwct_back
  import rwct_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int MAX_TEX_LOG2     = 8,
  parameter int MAX_SLICE_HEIGHT = 1048575
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  cmd_t cmd,
  input  logic cmd_empty,
  output logic cmd_pop,
  input  logic out_full,
  output logic out_push,
  output res_t out_data
);

  localparam int LHW = $clog2(MAX_SLICE_HEIGHT + 1);
  localparam int N1  = ROW_W + FRAC_BITS;
  localparam int N2  = MAX_TEX_LOG2 + FRAC_BITS + 1;
  localparam int DN  = (N1 > N2) ? N1 : N2;
  localparam int SW  = RAY_FRAC + FRAC_BITS;
  localparam int TXW = FRAC_BITS + MAX_TEX_LOG2;
  localparam int AW  = ((LHW > ROW_W) ? LHW : ROW_W) + 2;
  localparam int TL  = MAX_TEX_LOG2;

  back_state_t state, state_next;

  // column state
  logic [COL_W-1:0]  current_column;
  logic [ROW_W-1:0]  row_counter;
  logic [ROW_W-1:0]  slice_top;
  logic [ROW_W-1:0]  slice_bottom;
  logic [ACC_W-1:0]  texture_row_accum;
  logic [STEP_W-1:0] texture_row_step;
  logic [TL-1:0]     texture_column;
  logic [1:0]        chosen_texture;

  // setup working registers
  logic [DIST_W-1:0]  wd;
  logic               side;
  logic signed [15:0] rx;
  logic signed [15:0] ry;
  logic [23:0]        px;
  logic [23:0]        py;
  logic signed [40:0] prod;
  logic [LHW-1:0]     lh;
  logic [LHW-1:0]     start_off;

  logic          div_start;
  logic [DN-1:0] div_dividend;
  logic [DIV_D-1:0] div_divisor;
  logic          div_done;
  logic [DN-1:0] div_q;

  logic [3:0] wl;
  logic [3:0] hl;
  assign wl = (cfg.tex_width_log2 > 4'(MAX_TEX_LOG2)) ? 4'(MAX_TEX_LOG2) : cfg.tex_width_log2;
  assign hl = (cfg.tex_height_log2 > 4'(MAX_TEX_LOG2)) ? 4'(MAX_TEX_LOG2) : cfg.tex_height_log2;

  // pixel row
  logic [ROW_W-1:0] half_h;
  logic             row_live;
  logic             in_wall;
  logic [TL-1:0]    wmask;
  logic [TL-1:0]    hmask;
  logic [TL-1:0]    tx_m;
  logic [TL-1:0]    ty_m;
  logic [31:0]      idx_wide;
  res_t             pix_res;

  assign half_h   = cfg.screen_height >> 1;
  assign row_live = (row_counter < cfg.screen_height);
  assign in_wall  = (row_counter >= slice_top) && (row_counter < slice_bottom);
  assign wmask    = TL'(((TL+1)'(1) << wl) - (TL+1)'(1));
  assign hmask    = TL'(((TL+1)'(1) << hl) - (TL+1)'(1));
  assign tx_m     = texture_column & wmask;
  assign ty_m     = texture_row_accum[FRAC_BITS+TL-1:FRAC_BITS] & hmask;
  assign idx_wide = (32'(tx_m) << wl) + 32'(ty_m);

  always_comb begin
    pix_res            = '0;
    pix_res.out_column = current_column;
    pix_res.out_row    = row_counter;
    if (in_wall) begin
      pix_res.pixel_kind     = KIND_TEXEL;
      pix_res.texture_select = chosen_texture;
      pix_res.texel_index    = idx_wide[15:0];
    end else if (row_counter < half_h) begin
      pix_res.pixel_kind  = KIND_CEILING;
      pix_res.pixel_color = cfg.ceiling_color;
    end else begin
      pix_res.pixel_kind  = KIND_FLOOR;
      pix_res.pixel_color = cfg.floor_color;
    end
  end

  // texture column from the hit point
  logic [SW-1:0]  hit_sum;
  logic [FRAC_BITS-1:0] hit_frac;
  logic [TXW-1:0] tx_wide;
  logic [TL:0]    tx_mirror;
  logic [TL-1:0]  tx_calc;
  logic           mirror;

  assign hit_sum   = SW'({(side ? px : py), {RAY_FRAC{1'b0}}}) + SW'(prod);
  assign hit_frac  = hit_sum[SW-1:RAY_FRAC];
  assign tx_wide   = (TXW'(hit_frac) << wl) >> FRAC_BITS;
  assign tx_mirror = ((TL+1)'(1) << wl) - (TL+1)'(tx_wide[TL-1:0]) - (TL+1)'(1);
  assign mirror    = (!side && !rx[15] && (rx != 16'sd0)) || (side && ry[15]);
  assign tx_calc   = mirror ? tx_mirror[TL-1:0] : tx_wide[TL-1:0];

  // slice bounds from the slice height
  logic signed [AW-1:0] half_l_s;
  logic signed [AW-1:0] half_h_s;
  logic signed [AW-1:0] ds;
  logic signed [AW-1:0] de0;
  logic signed [AW-1:0] de1;
  logic signed [AW-1:0] de;
  logic signed [AW-1:0] hmax;

  assign half_l_s = AW'(lh >> 1);
  assign half_h_s = AW'(half_h);
  assign hmax     = AW'(cfg.screen_height) - AW'(1);
  assign ds       = (half_h_s > half_l_s) ? half_h_s - half_l_s : '0;
  assign de0      = half_l_s + half_h_s;
  assign de1      = (de0 > hmax) ? hmax : de0;
  assign de       = (de1 < ds) ? ds : de1;

  logic [63:0]    q64;
  logic [LHW-1:0] lh_sat;
  logic [STEP_W-1:0] step_sat;
  assign q64      = 64'(div_q);
  assign lh_sat   = ((wd == '0) || (q64 > 64'(MAX_SLICE_HEIGHT))) ?
                    LHW'(MAX_SLICE_HEIGHT) : LHW'(div_q);
  assign step_sat = (q64 > 64'(32'hFFFF_FFFF)) ? '1 : q64[STEP_W-1:0];

  rwct_div #(.N(DN), .D(DIV_D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!cmd_empty && cmd.command == CMD_SETUP) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV_H;
      ST_DIV_H: if (div_done) state_next = ST_SLICE;
      ST_SLICE: state_next = (lh != '0) ? ST_DIV_S : ST_MUL;
      ST_DIV_S: if (div_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_EMIT;
      ST_EMIT:  if (!out_full) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_data     = pix_res;
    div_start    = 1'b0;
    div_dividend = DN'(cfg.screen_height) << FRAC_BITS;
    div_divisor  = wd;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.command == CMD_SETUP || !row_live) begin
            cmd_pop = 1'b1;
          end else if (!out_full) begin
            cmd_pop  = 1'b1;
            out_push = 1'b1;
          end
        end
      end
      ST_LOAD: div_start = 1'b1;
      ST_SLICE: begin
        div_start    = (lh != '0);
        div_dividend = DN'(1) << (int'(hl) + FRAC_BITS);
        div_divisor  = DIV_D'(lh);
      end
      ST_EMIT: begin
        out_push                = !out_full;
        out_data                = '0;
        out_data.out_column     = current_column;
        out_data.pixel_kind     = KIND_DEPTH;
        out_data.texture_select = chosen_texture;
        out_data.depth          = wd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      current_column    <= '0;
      row_counter       <= '0;
      slice_top         <= '0;
      slice_bottom      <= '0;
      texture_row_accum <= '0;
      texture_row_step  <= '0;
      texture_column    <= '0;
      chosen_texture    <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (cmd_pop && cmd.command == CMD_SETUP) begin
            current_column <= cmd.column;
          end else if (out_push) begin
            row_counter <= row_counter + ROW_W'(1);
            if (in_wall) begin
              texture_row_accum <= texture_row_accum + ACC_W'(texture_row_step);
            end
          end
        end
        ST_LOAD: begin
          if (!side) begin
            if (rx[15]) chosen_texture <= 2'd0;
            else if (rx != 16'sd0) chosen_texture <= 2'd1;
          end else begin
            if (ry[15]) chosen_texture <= 2'd2;
            else if (ry != 16'sd0) chosen_texture <= 2'd3;
          end
        end
        ST_DIV_H: texture_column <= tx_calc;
        ST_SLICE: begin
          slice_top    <= ROW_W'(ds);
          slice_bottom <= ROW_W'(de);
          if (lh == '0) texture_row_step <= '0;
        end
        ST_DIV_S: if (div_done) texture_row_step <= step_sat;
        ST_MUL: texture_row_accum <= ACC_W'(start_off) * ACC_W'(texture_row_step);
        ST_EMIT: if (!out_full) row_counter <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_pop && cmd.command == CMD_SETUP) begin
      wd   <= cmd.wall_distance;
      side <= cmd.hit_side;
      rx   <= cmd.ray_dir_x;
      ry   <= cmd.ray_dir_y;
      px   <= cmd.pos_x;
      py   <= cmd.pos_y;
    end
    if (state == ST_LOAD) begin
      prod <= $signed({1'b0, wd}) * (side ? rx : ry);
    end
    if (state == ST_DIV_H && div_done) begin
      lh <= lh_sat;
    end
    if (state == ST_SLICE) begin
      start_off <= (half_l_s > half_h_s) ? LHW'(half_l_s - half_h_s) : '0;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) out_push |-> !out_full)
    else $error("result pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_H && !div_done) |=> (state == ST_DIV_H))
    else $error("left divide wait before quotient");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && out_push) |=> (row_counter == $past(row_counter) + ROW_W'(1)))
    else $error("row counter did not advance");
  assert property (@(posedge clk) disable iff (rst) slice_top <= slice_bottom)
    else $error("slice bounds inverted");
`endif

endmodule

>>> design/raycast_wall_column_texturer.sv
// top level of the raycast wall column texturer
// usage:
//   input channel is a queue: drive an item on the field ports with push high,
//   it is taken at a rising edge while full is low. command 0 is a column
//   setup, command 1 asks for the next row of the current column.
//   results come out of a queue: while empty is low the oldest result is on
//   the out ports; pop high at a rising edge takes it.
//   configuration: cfg_write with cfg_index and cfg_data writes one register
//   (0 screen height, 1 texture width log2, 2 texture height log2,
//   3 ceiling color, 4 floor color); write only while the block is idle.
// timing:
//   a pixel request passes from the request queue through the back end into
//   the result queue, and the back end serves one pixel request per cycle
//   while it is idle and the result queue is not full.
//   a setup request runs up to two bit-serial divisions on the one shared
//   divider (the second is skipped for a zero slice height) plus the load,
//   slice, multiply and emit steps, and ends with a depth result.
// reset: synchronous, active high; clears both queues, the column state and
//   the registers to their default values (480 rows, 64 by 64 textures).
// stall: when the result queue fills, the back end holds, then the request
//   queue fills and full rises; only requests past the last row are dropped.
module raycast_wall_column_texturer
  import rwct_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int MAX_TEX_LOG2     = 8,
  parameter int MAX_SLICE_HEIGHT = 1048575
) (
  input  logic               clk,
  input  logic               rst,
  // request side
  input  logic               push,
  output logic               full,
  input  logic               command,
  input  logic [11:0]        column,
  input  logic [23:0]        wall_distance,
  input  logic               hit_side,
  input  logic signed [15:0] ray_dir_x,
  input  logic signed [15:0] ray_dir_y,
  input  logic [23:0]        pos_x,
  input  logic [23:0]        pos_y,
  // configuration
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic [11:0]        out_column,
  output logic [10:0]        out_row,
  output logic [1:0]         pixel_kind,
  output logic [1:0]         texture_select,
  output logic [15:0]        texel_index,
  output logic [31:0]        pixel_color,
  output logic [23:0]        depth
);

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_pop;
  logic out_full;
  logic out_push;
  res_t res_in;
  res_t res_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height   <= 11'd480;
      cfg.tex_width_log2  <= 4'd6;
      cfg.tex_height_log2 <= 4'd6;
      cfg.ceiling_color   <= '0;
      cfg.floor_color     <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data[10:0];
        REG_TEX_WIDTH_LOG2:  cfg.tex_width_log2  <= cfg_data[3:0];
        REG_TEX_HEIGHT_LOG2: cfg.tex_height_log2 <= cfg_data[3:0];
        REG_CEILING_COLOR:   cfg.ceiling_color   <= cfg_data;
        REG_FLOOR_COLOR:     cfg.floor_color     <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: pack the request and queue it for the back end
  always_comb begin
    cmd_in.command       = command;
    cmd_in.column        = column;
    cmd_in.wall_distance = wall_distance;
    cmd_in.hit_side      = hit_side;
    cmd_in.ray_dir_x     = ray_dir_x;
    cmd_in.ray_dir_y     = ray_dir_y;
    cmd_in.pos_x         = pos_x;
    cmd_in.pos_y         = pos_y;
  end

  rwct_fifo #(.item_t(cmd_t), .DEPTH(4)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd      (cmd_pop),
    .rd_data (cmd_head),
    .empty   (cmd_empty)
  );

  // back: setup sequencer and row generator
  rwct_back #(
    .FRAC_BITS        (FRAC_BITS),
    .MAX_TEX_LOG2     (MAX_TEX_LOG2),
    .MAX_SLICE_HEIGHT (MAX_SLICE_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (res_in)
  );

  // result queue decouples the back end from a stalled receiver
  rwct_fifo #(.item_t(res_t), .DEPTH(4)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (out_push),
    .wr_data (res_in),
    .full    (out_full),
    .rd      (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign out_column     = res_head.out_column;
  assign out_row        = res_head.out_row;
  assign pixel_kind     = res_head.pixel_kind;
  assign texture_select = res_head.texture_select;
  assign texel_index    = res_head.texel_index;
  assign pixel_color    = res_head.pixel_color;
  assign depth          = res_head.depth;

endmodule
